// ===== design/ptu_pkg.sv =====
// Package: shared constants, types and the witness table for the primality unit.
package ptu_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned NumBases = 12;
  localparam int unsigned BaseIdxW = $clog2(NumBases + 1);
  localparam int unsigned ShiftW   = $clog2(WordBits + 1);
  localparam int unsigned QDepth   = 2;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [1:0] {
    CLS_NOT_PRIME = 2'd0,
    CLS_PRIME     = 2'd1,
    CLS_TEST      = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e  cls;
    word_t n;
  } job_t;

  function automatic word_t witness(input logic [BaseIdxW-1:0] idx);
    word_t w;
    unique case (idx)
      4'd0:    w = word_t'(2);
      4'd1:    w = word_t'(3);
      4'd2:    w = word_t'(5);
      4'd3:    w = word_t'(7);
      4'd4:    w = word_t'(11);
      4'd5:    w = word_t'(13);
      4'd6:    w = word_t'(17);
      4'd7:    w = word_t'(19);
      4'd8:    w = word_t'(23);
      4'd9:    w = word_t'(29);
      4'd10:   w = word_t'(31);
      4'd11:   w = word_t'(37);
      default: w = word_t'(37);
    endcase
    return w;
  endfunction

endpackage

// ===== design/primality_test_64bit_unit.sv =====
// Top level: deterministic 64-bit Miller-Rabin primality unit.
//  channel | valid   | ready   | payload
//  in      | valid_i | ready_o | candidate_i[63:0]
//  out     | valid_o | ready_i | prime_flag_o
// Trivial candidates pass through the front register, the queue and the back end's output state;
// odd ones run up to 12 bases, each up to 63 squarings plus multiplies, with every modular
// product done by shift-and-add.
// The bit-serial modular multiplier in the back end sets the rate.
// Reset clears all control; a queue of two transactions lets the front accept while back works.
module primality_test_64bit_unit import ptu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  word_t candidate_i,
  output logic  valid_o,
  input  logic  ready_i,
  output logic  prime_flag_o
);

  logic f_vld, f_rdy, b_vld, b_rdy;
  job_t f_job, b_job;

  ptu_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .candidate_i,
    .job_valid_o(f_vld), .job_ready_i(f_rdy), .job_o(f_job)
  );

  ptu_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_vld), .wr_ready_o(f_rdy), .wr_data_i(f_job),
    .rd_valid_o(b_vld), .rd_ready_i(b_rdy), .rd_data_o(b_job)
  );

  ptu_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_vld), .job_ready_o(b_rdy), .job_i(b_job),
    .valid_o, .ready_i, .prime_flag_o
  );

endmodule

// ===== design/ptu_front.sv =====
// Front end: accepts candidates and classifies trivial cases; any with the top bit set is marked not prime.
module ptu_front import ptu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  word_t candidate_i,
  output logic  job_valid_o,
  input  logic  job_ready_i,
  output job_t  job_o
);

  job_t job_q, job_d;
  logic vld_q;

  always_comb begin
    job_d.n = candidate_i;
    if (candidate_i[WordBits-1] || candidate_i < word_t'(2)) begin
      job_d.cls = CLS_NOT_PRIME;
    end else if (candidate_i == word_t'(2) || candidate_i == word_t'(3)) begin
      job_d.cls = CLS_PRIME;
    end else if (!candidate_i[0]) begin
      job_d.cls = CLS_NOT_PRIME;
    end else begin
      job_d.cls = CLS_TEST;
    end
  end

  assign ready_o     = !vld_q || job_ready_i;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== design/ptu_queue.sv =====
// Queue: short FIFO of classified jobs between front and back.
module ptu_queue import ptu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  job_t mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/ptu_back.sv =====
// Back end: Miller-Rabin sequencer with a bit-serial modular multiplier.
module ptu_back import ptu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic valid_o,
  input  logic ready_i,
  output logic prime_flag_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPLIT, ST_BASE, ST_PSQ, ST_PMUL, ST_CHK, ST_SQ, ST_SQCHK, ST_MUL, ST_OUT
  } state_e;

  state_e state_q, ret_q;
  word_t  n_q, d_q, e_q, x_q, a_q;
  logic [ShiftW-1:0]   s_q, r_q;
  logic [BaseIdxW-1:0] bi_q;
  logic flag_q;

  // multiplier: acc = ma*mb mod n, shift-and-add
  word_t acc_q, ma_q, mb_q;
  word_t nm1;
  word_t add_acc, add_dbl;

  assign nm1 = n_q - 1'b1;

  function automatic word_t addm(input word_t p, input word_t q, input word_t m);
    word_t t;
    t = m - q;
    return (p >= t) ? (p - t) : (p + q);
  endfunction

  assign add_acc = addm(acc_q, ma_q, n_q);
  assign add_dbl = addm(ma_q, ma_q, n_q);

  assign job_ready_o = state_q == ST_IDLE;
  assign valid_o     = state_q == ST_OUT;
  assign prime_flag_o = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      flag_q  <= 1'b0;
      bi_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (job_valid_i) begin
          n_q <= job_i.n;
          d_q <= job_i.n - 1'b1;
          s_q <= '0;
          bi_q <= '0;
          unique case (job_i.cls)
            CLS_TEST:      state_q <= ST_SPLIT;
            CLS_PRIME:     begin flag_q <= 1'b1; state_q <= ST_OUT; end
            default:       begin flag_q <= 1'b0; state_q <= ST_OUT; end
          endcase
        end
        ST_SPLIT: begin
          if (!d_q[0]) begin
            d_q <= d_q >> 1;
            s_q <= s_q + 1'b1;
          end else begin
            state_q <= ST_BASE;
          end
        end
        ST_BASE: begin
          if (bi_q == BaseIdxW'(NumBases) || witness(bi_q) >= n_q) begin
            flag_q  <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            a_q <= witness(bi_q);
            e_q <= d_q;
            x_q <= word_t'(1);
            state_q <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          if (e_q == '0) begin
            state_q <= ST_CHK;
          end else if (e_q[0]) begin
            acc_q <= '0; ma_q <= x_q; mb_q <= a_q;
            ret_q <= ST_PSQ; state_q <= ST_MUL;
          end else begin
            state_q <= ST_PSQ;
          end
        end
        ST_PSQ: begin
          if (e_q[0]) x_q <= acc_q;
          acc_q <= '0; ma_q <= a_q; mb_q <= a_q;
          e_q <= e_q >> 1;
          ret_q <= ST_SQCHK; state_q <= ST_MUL;
          r_q <= '0;
        end
        ST_CHK: begin
          if (x_q == word_t'(1) || x_q == nm1) begin
            bi_q <= bi_q + 1'b1; state_q <= ST_BASE;
          end else begin
            r_q <= ShiftW'(1);
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (r_q >= s_q) begin
            flag_q <= 1'b0; state_q <= ST_OUT;
          end else begin
            acc_q <= '0; ma_q <= x_q; mb_q <= x_q;
            ret_q <= ST_SQCHK; state_q <= ST_MUL;
          end
        end
        ST_SQCHK: begin
          if (r_q == '0) begin
            a_q <= acc_q; state_q <= ST_PMUL;
          end else if (acc_q == nm1) begin
            bi_q <= bi_q + 1'b1; state_q <= ST_BASE;
          end else begin
            x_q <= acc_q; r_q <= r_q + 1'b1; state_q <= ST_SQ;
          end
        end
        ST_MUL: begin
          if (mb_q == '0) begin
            state_q <= ret_q;
          end else begin
            if (mb_q[0]) acc_q <= add_acc;
            ma_q <= add_dbl;
            mb_q <= mb_q >> 1;
          end
        end
        ST_OUT: if (ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  ast_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(prime_flag_o))
    else $error("result dropped while stalled");
  ast_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> !valid_o)
    else $error("idle and output at once");
  ast_mul_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> (ret_q == ST_PSQ || ret_q == ST_SQCHK))
    else $error("bad multiply return");

endmodule
